// ----- hdl/view_frustum_cull_test_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the view frustum cull test core
// Concurrent assertion helpers, clocked on the rising edge, with reset off.
// ---------------------------------------------------------------------------
`ifndef VIEW_FRUSTUM_CULL_TEST_CORE_DEFINES_SVH
`define VIEW_FRUSTUM_CULL_TEST_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define VFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define VFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ----- hdl/vfc_pkg.sv -----
// ---------------------------------------------------------------------------
// View frustum cull package
// Field widths, item kind codes, defaults and the controller/datapath links.
// ---------------------------------------------------------------------------
package vfc_pkg;

  // Payload field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PIDX_W  = 3;
  localparam int unsigned COEF_W  = 32;

  // Exact products and the sum of up to seven of them
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned SUM_W   = PROD_W + 4;

  // Parameter defaults
  localparam int unsigned PLANE_COUNT_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Item kinds; the fourth code is unused and ignored
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX    = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write_plane;
    logic load_item;
    logic issue;
    logic issue_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;
    logic visible;
  } stat_t;

endpackage

// ----- hdl/vfc_if.sv -----
// ---------------------------------------------------------------------------
// View frustum cull channel interfaces
// Valid/ready channels for the input items and for the result items.
// ---------------------------------------------------------------------------

// Input items: plane writes and object tests
interface vfc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [vfc_pkg::KIND_W-1:0]    kind;
  logic        [vfc_pkg::PIDX_W-1:0]    plane_index;
  logic signed [vfc_pkg::COEF_W-1:0]    coef_a;
  logic signed [vfc_pkg::COEF_W-1:0]    coef_b;
  logic signed [vfc_pkg::COEF_W-1:0]    coef_c;
  logic signed [vfc_pkg::COEF_W-1:0]    coef_d;
  logic signed [vfc_pkg::COEF_W-1:0]    center_x;
  logic signed [vfc_pkg::COEF_W-1:0]    center_y;
  logic signed [vfc_pkg::COEF_W-1:0]    center_z;
  logic signed [vfc_pkg::COEF_W-1:0]    extent_x;
  logic signed [vfc_pkg::COEF_W-1:0]    extent_y;
  logic signed [vfc_pkg::COEF_W-1:0]    extent_z;

  modport source (
    output valid, kind, plane_index, coef_a, coef_b, coef_c, coef_d,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, kind, plane_index, coef_a, coef_b, coef_c, coef_d,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

// Result items: one visible flag per object test
interface vfc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

// ----- hdl/view_frustum_cull_test_core.sv -----
// ---------------------------------------------------------------------------
// View frustum cull test core
// Holds the frustum planes and tests spheres, points and boxes against them.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                       Per transaction
//  in_i     in   kind, plane_index, coef_a..d, center, extent  one item
//  out_o    out  visible                                       one test result
//
// A plane write gives no result; an unused kind is dropped.
// A sphere or box test offers its result in the same cycle as the next item can
// be taken: the controller walks the plane store one plane per cycle into a
// five-stage multiply and add pipeline, and the next item waits for its end.
// Reset clears the plane store, which culls all but positive-radius spheres.
// A result waits in the output register while the next item is accepted; a
// later result that finds it still occupied holds the input until it is taken.
// ---------------------------------------------------------------------------
module view_frustum_cull_test_core #(
  parameter int unsigned PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned FRAC_BITS   = vfc_pkg::FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  vfc_in_if.sink     in_i,
  vfc_out_if.source  out_o
);

  localparam int unsigned IdxW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  vfc_pkg::cmd_t   cmd;
  vfc_pkg::stat_t  stat;
  logic [IdxW-1:0] plane_sel;

  // Controller
  vfc_ctrl #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_kind_i     (in_i.kind),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_visible_o (out_o.visible),
    .cmd_o         (cmd),
    .plane_sel_o   (plane_sel),
    .stat_i        (stat)
  );

  // Datapath
  vfc_datapath #(
    .PLANE_COUNT (PLANE_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .plane_sel_i   (plane_sel),
    .kind_i        (in_i.kind),
    .plane_index_i (in_i.plane_index),
    .coef_a_i      (in_i.coef_a),
    .coef_b_i      (in_i.coef_b),
    .coef_c_i      (in_i.coef_c),
    .coef_d_i      (in_i.coef_d),
    .center_x_i    (in_i.center_x),
    .center_y_i    (in_i.center_y),
    .center_z_i    (in_i.center_z),
    .extent_x_i    (in_i.extent_x),
    .extent_y_i    (in_i.extent_y),
    .extent_z_i    (in_i.extent_z),
    .stat_o        (stat)
  );

endmodule

// ----- hdl/vfc_ctrl.sv -----
// ---------------------------------------------------------------------------
// View frustum cull controller
// Sequences the plane walk for each test and owns the result register.
// ---------------------------------------------------------------------------
module vfc_ctrl #(
  parameter int unsigned PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF,
  localparam int unsigned IdxW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [vfc_pkg::KIND_W-1:0]  in_kind_i,
  output logic                        in_ready_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_visible_o,
  output vfc_pkg::cmd_t               cmd_o,
  output logic [IdxW-1:0]             plane_sel_o,
  input  vfc_pkg::stat_t              stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_HOLD
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PLANE_COUNT - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_visible_q, out_visible_d;
  logic            pend_q, pend_d;
  logic            accept;
  logic            is_test;

  // Handshake and commands
  always_comb begin
    in_ready_o          = (state_q == S_IDLE);
    accept              = in_valid_i & in_ready_o;
    is_test             = (in_kind_i == vfc_pkg::KIND_SPHERE) ||
                          (in_kind_i == vfc_pkg::KIND_BOX);
    cmd_o.write_plane   = accept & (in_kind_i == vfc_pkg::KIND_WRITE);
    cmd_o.load_item     = accept & is_test;
    cmd_o.issue         = (state_q == S_ISSUE);
    cmd_o.issue_last    = (state_q == S_ISSUE) && (cnt_q == LastIdx);
    plane_sel_o         = cnt_q;
  end

  // Next state and result register
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_visible_d = out_visible_q;
    pend_d        = pend_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load_item) begin
          state_d = S_ISSUE;
          cnt_d   = '0;
        end
      end
      S_ISSUE: begin
        if (cnt_q == LastIdx) begin
          state_d = S_WAIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (stat_i.done) begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_d   = 1'b1;
            out_visible_d = stat_i.visible;
            state_d       = S_IDLE;
          end else begin
            pend_d  = stat_i.visible;
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // The previous result is still waiting; hand over once it is taken
        if (out_ready_i) begin
          out_valid_d   = 1'b1;
          out_visible_d = pend_q;
          state_d       = S_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_visible_q <= 1'b0;
      pend_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      out_visible_q <= out_visible_d;
      pend_q        <= pend_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_visible_o = out_visible_q;

endmodule

// ----- hdl/vfc_datapath.sv -----
// ---------------------------------------------------------------------------
// View frustum cull datapath
// Plane store and the pipelined signed-distance test, one plane per cycle.
// ---------------------------------------------------------------------------
module vfc_datapath #(
  parameter int unsigned PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned FRAC_BITS   = vfc_pkg::FRAC_BITS_DEF,
  localparam int unsigned IdxW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vfc_pkg::cmd_t                      cmd_i,
  input  logic [IdxW-1:0]                    plane_sel_i,
  input  logic        [vfc_pkg::KIND_W-1:0]  kind_i,
  input  logic        [vfc_pkg::PIDX_W-1:0]  plane_index_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  coef_a_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  coef_b_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  coef_c_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  coef_d_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  center_x_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  center_y_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  center_z_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  extent_x_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  extent_y_i,
  input  logic signed [vfc_pkg::COEF_W-1:0]  extent_z_i,
  output vfc_pkg::stat_t                     stat_o
);

  localparam int unsigned W    = vfc_pkg::COEF_W;
  localparam int unsigned PW   = vfc_pkg::PROD_W;
  localparam int unsigned SW   = vfc_pkg::SUM_W;
  localparam int unsigned RowW = 4 * W;

  // Magnitude of a product, widened to the sum width
  function automatic logic signed [SW-1:0] abs_ext(input logic signed [PW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    return e[SW-1] ? -e : e;
  endfunction

  // Plane store: one row {a, b, c, d} per plane, cleared at reset
  logic [PLANE_COUNT-1:0][RowW-1:0] store_q;
  logic                             idx_ok;

  assign idx_ok = {1'b0, plane_index_i} < (vfc_pkg::PIDX_W + 1)'(PLANE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (cmd_i.write_plane && idx_ok) begin
      store_q[plane_index_i[IdxW-1:0]] <= {coef_a_i, coef_b_i, coef_c_i, coef_d_i};
    end
  end

  // Object operands, held for the whole plane walk
  logic signed [W-1:0] cx_q, cy_q, cz_q, ex_q, ey_q, ez_q;
  logic                box_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      cz_q  <= center_z_i;
      ex_q  <= extent_x_i;
      ey_q  <= extent_y_i;
      ez_q  <= extent_z_i;
      box_q <= (kind_i == vfc_pkg::KIND_BOX);
    end
  end

  // Pipeline control: read, multiply, two add stages
  logic r_vld_q, r_last_q, m_vld_q, m_last_q;
  logic s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q   <= 1'b0;
      r_last_q  <= 1'b0;
      m_vld_q   <= 1'b0;
      m_last_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      r_vld_q   <= cmd_i.issue;
      r_last_q  <= cmd_i.issue_last;
      m_vld_q   <= r_vld_q;
      m_last_q  <= r_last_q;
      s1_vld_q  <= m_vld_q;
      s1_last_q <= m_last_q;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Read stage: the selected plane row
  logic [RowW-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      row_q <= store_q[plane_sel_i];
    end
  end

  // Multiply stage: centre products, half-size products and the scaled offset
  logic signed [W-1:0]  pl_a, pl_b, pl_c, pl_d;
  logic signed [W-1:0]  hx, hy, hz;
  logic signed [W:0]    off_sum;
  logic signed [PW-1:0] m_pa_q, m_pb_q, m_pc_q, m_qa_q, m_qb_q, m_qc_q;
  logic signed [SW-1:0] m_off_q;

  always_comb begin
    pl_a    = row_q[RowW-1 -: W];
    pl_b    = row_q[RowW-W-1 -: W];
    pl_c    = row_q[RowW-2*W-1 -: W];
    pl_d    = row_q[W-1:0];
    hx      = ex_q >>> 1;
    hy      = ey_q >>> 1;
    hz      = ez_q >>> 1;
    // A sphere adds its radius to the plane offset before scaling
    off_sum = (W + 1)'(pl_d) + (box_q ? '0 : (W + 1)'(ex_q));
  end

  always_ff @(posedge clk_i) begin
    m_pa_q  <= pl_a * cx_q;
    m_pb_q  <= pl_b * cy_q;
    m_pc_q  <= pl_c * cz_q;
    m_qa_q  <= pl_a * hx;
    m_qb_q  <= pl_b * hy;
    m_qc_q  <= pl_c * hz;
    m_off_q <= SW'(off_sum) <<< FRAC_BITS;
  end

  // First add stage: pairwise sums; the corner terms only count for a box
  logic signed [SW-1:0] s1_lin_q, s1_k_q, s1_q_q, s1_qc_q;

  always_ff @(posedge clk_i) begin
    s1_lin_q <= SW'(m_pa_q) + SW'(m_pb_q);
    s1_k_q   <= SW'(m_pc_q) + m_off_q;
    s1_q_q   <= box_q ? abs_ext(m_qa_q) + abs_ext(m_qb_q) : '0;
    s1_qc_q  <= box_q ? abs_ext(m_qc_q) : '0;
  end

  // Second add stage
  logic signed [SW-1:0] s2_x_q, s2_y_q;

  always_ff @(posedge clk_i) begin
    s2_x_q <= s1_lin_q + s1_k_q;
    s2_y_q <= s1_q_q + s1_qc_q;
  end

  // Final sum, cull decision and accumulation over the planes
  logic signed [SW-1:0] plane_dist;
  logic                 le_zero;
  logic                 culled_q;
  logic                 done_q;

  assign plane_dist = s2_x_q + s2_y_q;
  assign le_zero    = plane_dist[SW-1] || (plane_dist == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      culled_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= s2_vld_q & s2_last_q;
      if (cmd_i.load_item) begin
        culled_q <= 1'b0;
      end else if (s2_vld_q) begin
        culled_q <= culled_q | le_zero;
      end
    end
  end

  assign stat_o.done    = done_q;
  assign stat_o.visible = ~culled_q;

endmodule

// ----- hdl/vfc_checker.sv -----
// ---------------------------------------------------------------------------
// View frustum cull port checker
// Watches the top-level channels over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "view_frustum_cull_test_core_defines.svh"

module vfc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [vfc_pkg::KIND_W-1:0]  in_kind_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_visible_i
);

  logic in_acc;
  logic in_test;

  assign in_acc  = in_valid_i & in_ready_i;
  assign in_test = (in_kind_i == vfc_pkg::KIND_SPHERE) || (in_kind_i == vfc_pkg::KIND_BOX);

  // A pending result stays offered, unchanged, until it is taken.
  `VFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result withdrawn")
  `VFC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_visible_i), "stalled result changed")

  // A plane write never produces a result.
  `VFC_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_acc && (in_kind_i == vfc_pkg::KIND_WRITE) && !out_valid_i, !out_valid_i, "plane write produced a result")

  // Once a test is taken, no further item is accepted while it runs.
  `VFC_ASSERT_NEXT(a_test_busy, clk_i, rst_ni, in_acc && in_test, !in_ready_i, "item accepted during a test")

endmodule

bind view_frustum_cull_test_core vfc_checker u_vfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_visible_i (out_o.visible)
);

// ----- test/vfc_visibility_checker.sv -----
// ---------------------------------------------------------------------------
// View frustum cull visibility checker
// Watches the item and result channels of the cull test core. It keeps its
// own copy of the plane store, works out the visible flag of every accepted
// sphere or box test and compares each result transaction with the oldest
// outstanding flag. Failures and outstanding flags are handed to the bench.
// ---------------------------------------------------------------------------
module vfc_visibility_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  vfc_in_if           in_mon,
  vfc_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import vfc_pkg::*;

  localparam int unsigned PLANES       = PLANE_COUNT_DEF;
  localparam int unsigned FRAC         = FRAC_BITS_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow plane store: a, b, c and d of each plane
  logic signed [COEF_W-1:0] plane_coef [PLANES][4];

  // Visible flags still owed by the block, oldest first
  bit visible_expected_q [$];

  // Exact signed distance test of one object against every stored plane.
  // Products are exact in 64 bits and summed in 128 bits, so nothing rounds.
  function automatic bit predict_visible(input logic [KIND_W-1:0] kind,
                                         input logic signed [COEF_W-1:0] ctr [3],
                                         input logic signed [COEF_W-1:0] ext [3]);
    logic signed [127:0] plane_dist;
    logic signed [127:0] term;
    longint              prod;
    longint              half_size;
    bit                  culled;
    culled = 1'b0;
    for (int p = 0; p < PLANES; p++) begin
      plane_dist = '0;
      for (int k = 0; k < 3; k++) begin
        prod       = longint'(plane_coef[p][k]) * longint'(ctr[k]);
        term       = 128'(prod);
        plane_dist = plane_dist + term;
      end
      prod       = longint'(plane_coef[p][3]) <<< FRAC;
      term       = 128'(prod);
      plane_dist = plane_dist + term;
      if (kind == KIND_SPHERE) begin
        // The radius is added as given, even when it is negative.
        prod       = longint'(ext[0]) <<< FRAC;
        term       = 128'(prod);
        plane_dist = plane_dist + term;
      end else begin
        // Farthest corner: the half size rounds towards minus infinity and
        // each product enters by its magnitude.
        for (int k = 0; k < 3; k++) begin
          half_size = longint'(ext[k] >>> 1);
          prod      = longint'(plane_coef[p][k]) * half_size;
          if (prod < 0) begin
            prod = -prod;
          end
          term       = 128'(prod);
          plane_dist = plane_dist + term;
        end
      end
      if (plane_dist <= 0) begin
        culled = 1'b1;
      end
    end
    return !culled;
  endfunction

  // Compare result transactions first, then take in the new item, since a
  // result can never belong to an item accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [COEF_W-1:0] ctr [3];
    logic signed [COEF_W-1:0] ext [3];
    bit                       want;
    if (!rst_ni) begin
      for (int p = 0; p < PLANES; p++) begin
        for (int k = 0; k < 4; k++) begin
          plane_coef[p][k] = '0;
        end
      end
      visible_expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (visible_expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("Result visible=%0b arrived with no test outstanding", out_mon.visible);
          end
        end else begin
          want = visible_expected_q.pop_front();
          if (out_mon.visible !== want) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("Visible flag mismatch: expected %0b, got %0b", want, out_mon.visible);
            end
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.kind)
          KIND_WRITE: begin
            // Writes to a plane beyond the store are dropped.
            if (in_mon.plane_index < PLANES) begin
              plane_coef[in_mon.plane_index][0] = in_mon.coef_a;
              plane_coef[in_mon.plane_index][1] = in_mon.coef_b;
              plane_coef[in_mon.plane_index][2] = in_mon.coef_c;
              plane_coef[in_mon.plane_index][3] = in_mon.coef_d;
            end
          end
          KIND_SPHERE, KIND_BOX: begin
            ctr[0] = in_mon.center_x;
            ctr[1] = in_mon.center_y;
            ctr[2] = in_mon.center_z;
            ext[0] = in_mon.extent_x;
            ext[1] = in_mon.extent_y;
            ext[2] = in_mon.extent_z;
            visible_expected_q.push_back(predict_visible(in_mon.kind, ctr, ext));
          end
          default: begin
            // The unused kind is ignored by the block.
          end
        endcase
      end
    end
    pending_o = visible_expected_q.size();
  end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// View frustum cull test core bench
// Drives plane writes, sphere, point and box tests into the core: a directed
// pass over the boundary cases, then a long random pass with bursts of idling
// on both channels. The visibility checker predicts and compares the results.
// ---------------------------------------------------------------------------
module tb;
  import vfc_pkg::*;

  localparam int unsigned PLANES       = PLANE_COUNT_DEF;
  localparam int          ONE          = 1 << FRAC_BITS_DEF;
  localparam int          MOST_NEG     = int'(32'h8000_0000);
  localparam int          MOST_POS     = int'(32'h7fff_ffff);
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned TEST_ITEMS   = 1800;
  localparam int unsigned CALM_ITEMS   = 300;
  localparam int unsigned SETTLE_CYCLES = 2 * (PLANE_COUNT_DEF + 6);
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [PIDX_W-1:0]        pidx;
    logic signed [COEF_W-1:0] coef [4];
    logic signed [COEF_W-1:0] ctr  [3];
    logic signed [COEF_W-1:0] ext  [3];
  } cull_item_t;

  logic        clk_i;
  logic        rst_ni;
  bit          idling_on;
  int unsigned check_failures;
  int unsigned visible_pending;
  int unsigned cycles;
  int unsigned sent;

  vfc_in_if  in_ch ();
  vfc_out_if out_ch ();

  view_frustum_cull_test_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  vfc_visibility_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (check_failures),
    .pending_o    (visible_pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Mostly small signed Q16.16 values, with the odd full-range word.
  function automatic int near_value(input int unsigned span);
    if ($urandom_range(0, 7) == 0) begin
      return $urandom;
    end
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Sizes and radii: mostly positive, sometimes negative or full range.
  function automatic int rand_extent();
    if ($urandom_range(0, 7) == 0) begin
      return near_value(8 * ONE);
    end
    return int'($urandom_range(0, 8 * ONE));
  endfunction

  // A plane write; the object fields carry noise.
  function automatic cull_item_t plane_item(input logic [PIDX_W-1:0] idx,
                                            input int a, input int b,
                                            input int c, input int d);
    cull_item_t it;
    it.kind = KIND_WRITE;
    it.pidx = idx;
    it.coef = '{a, b, c, d};
    it.ctr  = '{$urandom, $urandom, $urandom};
    it.ext  = '{$urandom, $urandom, $urandom};
    return it;
  endfunction

  // An object test; the plane fields carry noise.
  function automatic cull_item_t object_item(input logic [KIND_W-1:0] kind,
                                             input int cx, input int cy, input int cz,
                                             input int ex, input int ey, input int ez);
    cull_item_t it;
    it.kind = kind;
    it.pidx = PIDX_W'($urandom);
    it.coef = '{$urandom, $urandom, $urandom, $urandom};
    it.ctr  = '{cx, cy, cz};
    it.ext  = '{ex, ey, ez};
    return it;
  endfunction

  // Present one item from a falling edge and hold it until its transaction.
  task automatic send_item(input cull_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_ch.kind        = it.kind;
    in_ch.plane_index = it.pidx;
    in_ch.coef_a      = it.coef[0];
    in_ch.coef_b      = it.coef[1];
    in_ch.coef_c      = it.coef[2];
    in_ch.coef_d      = it.coef[3];
    in_ch.center_x    = it.ctr[0];
    in_ch.center_y    = it.ctr[1];
    in_ch.center_z    = it.ctr[2];
    in_ch.extent_x    = it.ext[0];
    in_ch.extent_y    = it.ext[1];
    in_ch.extent_z    = it.ext[2];
    in_ch.valid       = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding flag has come back.
  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (visible_pending != 0) @(negedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    cull_item_t  it;
    int unsigned pick;
    logic [PIDX_W-1:0] idx;

    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_WRITE;
    in_ch.plane_index = '0;
    in_ch.coef_a      = '0;
    in_ch.coef_b      = '0;
    in_ch.coef_c      = '0;
    in_ch.coef_d      = '0;
    in_ch.center_x    = '0;
    in_ch.center_y    = '0;
    in_ch.center_z    = '0;
    in_ch.extent_x    = '0;
    in_ch.extent_y    = '0;
    in_ch.extent_z    = '0;
    idling_on         = 1'b1;
    rst_ni            = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Cleared planes: a point is culled, a small positive radius is not,
    // and any box is culled.
    send_item(object_item(KIND_SPHERE, 0, 0, 0, 0, $urandom, $urandom));
    send_item(object_item(KIND_SPHERE, 0, 0, 0, 1, $urandom, $urandom));
    send_item(object_item(KIND_BOX, $urandom, $urandom, $urandom,
                          MOST_POS, MOST_POS, MOST_POS));

    // Items the block must ignore: the unused kind and writes past the store.
    send_item(object_item(KIND_UNUSED, 0, 0, 0, ONE, ONE, ONE));
    send_item(plane_item(3'd6, ONE, ONE, ONE, MOST_NEG));
    send_item(plane_item(3'd7, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));

    // A cube frustum from -8.0 to 8.0 on every axis.
    send_item(plane_item(3'd0,  ONE,    0,    0, 8 * ONE));
    send_item(plane_item(3'd1, -ONE,    0,    0, 8 * ONE));
    send_item(plane_item(3'd2,    0,  ONE,    0, 8 * ONE));
    send_item(plane_item(3'd3,    0, -ONE,    0, 8 * ONE));
    send_item(plane_item(3'd4,    0,    0,  ONE, 8 * ONE));
    send_item(plane_item(3'd5,    0,    0, -ONE, 8 * ONE));

    // Points and spheres around the x = 8.0 face: touching counts as culled.
    send_item(object_item(KIND_SPHERE, 0, 0, 0, 0, 0, 0));
    send_item(object_item(KIND_SPHERE, 8 * ONE, 0, 0, 0, 0, 0));
    send_item(object_item(KIND_SPHERE, 9 * ONE, 0, 0, ONE, 0, 0));
    send_item(object_item(KIND_SPHERE, 9 * ONE, 0, 0, ONE + 1, 0, 0));
    send_item(object_item(KIND_SPHERE, 0, 0, 0, -8 * ONE, 0, 0));

    // Boxes beside the same face, with positive, negative and tiny sizes.
    send_item(object_item(KIND_BOX, 9 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_item(object_item(KIND_BOX, 9 * ONE, 0, 0, 2 * ONE + 2, ONE, ONE));
    send_item(object_item(KIND_BOX, 9 * ONE, 0, 0, -2 * ONE - 2, -ONE, -ONE));
    send_item(object_item(KIND_BOX, 9 * ONE, 0, 0, -1, -1, -1));
    send_item(object_item(KIND_BOX, 9 * ONE, 0, 0, 1, 1, 1));

    // Extreme coefficients, centres and extents.
    send_item(plane_item(3'd0, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS));
    send_item(object_item(KIND_SPHERE, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, 0, 0));
    send_item(object_item(KIND_SPHERE, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, 0, 0));
    send_item(object_item(KIND_BOX, MOST_POS, MOST_POS, MOST_POS,
                          MOST_NEG, MOST_NEG, MOST_NEG));
    send_item(object_item(KIND_BOX, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_POS, MOST_NEG, MOST_POS));

    wait_results_drained();

    // Random part: plane updates amid a stream of sphere and box tests,
    // with some ignored items mixed in.
    sent = 0;
    while (sent < TEST_ITEMS) begin
      if (sent == TEST_ITEMS / 2) begin
        wait_results_drained();
      end
      if (sent >= TEST_ITEMS - CALM_ITEMS) begin
        idling_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 15) == 0) begin
          idx = PIDX_W'($urandom_range(PLANES, 7));
        end else begin
          idx = PIDX_W'($urandom_range(0, PLANES - 1));
        end
        send_item(plane_item(idx, near_value(ONE), near_value(ONE), near_value(ONE),
                             ($urandom_range(0, 7) == 0) ? near_value(48 * ONE)
                                                         : int'($urandom_range(0, 48 * ONE))));
      end else if (pick < 15) begin
        send_item(object_item(KIND_UNUSED, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom));
      end else begin
        it = object_item((pick[0]) ? KIND_BOX : KIND_SPHERE,
                         near_value(24 * ONE), near_value(24 * ONE), near_value(24 * ONE),
                         rand_extent(), rand_extent(), rand_extent());
        if (it.kind == KIND_SPHERE && $urandom_range(0, 15) == 0) begin
          it.ext[0] = '0;
        end
        send_item(it);
      end
      sent++;
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (check_failures == 0 && visible_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/vfc_pkg.sv
hdl/vfc_if.sv
hdl/vfc_ctrl.sv
hdl/vfc_datapath.sv
hdl/view_frustum_cull_test_core.sv
hdl/vfc_checker.sv
test/vfc_visibility_checker.sv
test/tb.sv
